// File: rtl/pscm_pkg.sv
// ----------------------------------------------------------------------------
// pscm_pkg
// Shared types, codes, color stops and elaboration-time helpers for the
// particle scalar colormap.
// ----------------------------------------------------------------------------
package pscm_pkg;

  typedef enum logic [1:0] {
    CFG_FIELD_SELECT = 2'd0,
    CFG_LOG_SCALE    = 2'd1,
    CFG_BRIGHTNESS   = 2'd2,
    CFG_INV_MAXIMUM  = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    FIELD_DENSITY = 3'd0,
    FIELD_ENERGY  = 3'd1,
    FIELD_SPEED   = 3'd2,
    FIELD_ACCEL   = 3'd3,
    FIELD_VEL_X   = 3'd4,
    FIELD_VEL_Y   = 3'd5,
    FIELD_VEL_Z   = 3'd6,
    FIELD_SPARE   = 3'd7
  } field_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  localparam int          ONE_Q16    = 65536;
  localparam logic [16:0] SEQ_B1     = 17'd26214;
  localparam logic [16:0] SEQ_B2     = 17'd52429;
  localparam logic [14:0] SEG_LEN0   = 15'd26214;
  localparam logic [14:0] SEG_LEN1   = 15'd26215;
  localparam logic [14:0] SEG_LEN2   = 15'd13107;
  localparam logic [26:0] SEG_RCP0   = 27'((64'd1 << 40) / 64'd26214);
  localparam logic [26:0] SEG_RCP1   = 27'((64'd1 << 40) / 64'd26215);
  localparam logic [26:0] SEG_RCP2   = 27'((64'd1 << 40) / 64'd13107);

  // Stop colors of the sequential ramp: deep blue, cyan, yellow, white.
  function automatic logic [15:0] seq_stop(input logic [1:0] idx, input logic [1:0] ch);
    logic [47:0] row;
    unique case (idx)
      2'd0:    row = {16'd2294, 16'd5243, 16'd20971};
      2'd1:    row = {16'd1311, 16'd47185, 16'd53739};
      2'd2:    row = {16'd65535, 16'd53739, 16'd7864};
      default: row = {16'd65535, 16'd64224, 16'd60292};
    endcase
    unique case (ch)
      2'd0:    return row[47:32];
      2'd1:    return row[31:16];
      default: return row[15:0];
    endcase
  endfunction

  // Restoring division, used only while building the log table.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      if (r >= b) begin
        r = r - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // log2(num/den) in Q.30 by repeated squaring, truncating.
  function automatic logic [63:0] log2_q30(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] m;
    logic [63:0] frac;
    logic [2:0]  e;
    e = '0;
    frac = '0;
    for (int s = 0; s < 5; s++) begin
      if (e == 3'(s) && num >= (den << (s + 1))) e = 3'(s + 1);
    end
    m = udiv64(num << 30, den << e);
    for (int s = 0; s < 30; s++) begin
      m = (m * m) >> 30;
      frac = {frac[62:0], 1'b0};
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return ({61'd0, e} << 30) | frac;
  endfunction

  function automatic logic [63:0] log_rom_entry(input logic [63:0] k, input logic [63:0] n);
    logic [63:0] top;
    logic [63:0] l;
    top = log2_q30(64'd31 * n, n);
    l   = log2_q30(n + 64'd30 * k, n);
    return udiv64(l * 64'd65536 + (top >> 1), top);
  endfunction

endpackage

// File: rtl/pscm_seq_blend.sv
// ----------------------------------------------------------------------------
// pscm_seq_blend
// Blends the two stop colors of one ramp segment by a Q1.16 amount.
// ----------------------------------------------------------------------------
module pscm_seq_blend (
  input  logic [1:0]   seg,
  input  logic [16:0]  amount,
  output pscm_pkg::rgb_t color
);
  import pscm_pkg::*;

  logic [15:0] chan [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [15:0] ca;
      logic [15:0] cb;
      logic [32:0] prod;
      ca = seq_stop(seg, 2'(c));
      cb = seq_stop(seg + 2'd1, 2'(c));
      // The step is truncated toward the first stop of the segment.
      if (cb >= ca) begin
        prod    = 33'(cb - ca) * 33'(amount);
        chan[c] = ca + prod[31:16];
      end else begin
        prod    = 33'(ca - cb) * 33'(amount);
        chan[c] = ca - prod[31:16];
      end
    end
  end

  assign color.red   = chan[0];
  assign color.green = chan[1];
  assign color.blue  = chan[2];

endmodule

// File: rtl/particle_scalar_colormap.sv
// ----------------------------------------------------------------------------
// particle_scalar_colormap
// Picks one scalar of a particle, normalizes it, optionally compresses it
// through an interpolated log table, applies brightness and maps it to RGB.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, pos_*, *_value, vel_* | into block
//  out     | out_valid, out_stall, out_*, red/green/blue| out of block
//  cfg     | cfg_write, cfg_index, cfg_data            | into block
//
// One particle is taken every clock while in_stall is low.
// Each of the nine register stages holds a short piece of arithmetic: one
// wide multiply, or a few narrow multiplies by constants or stop colors.
// A stage moves when it is empty or the stage after it moves, so bubbles
// close up and a stalled output backs up the pipeline one stage at a time.
// Reset clears the valid bits and loads the register defaults.
module particle_scalar_colormap #(
  parameter int LOG_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] density_value,
  input  logic signed [31:0] energy_value,
  input  logic signed [31:0] speed_value,
  input  logic signed [31:0] accel_value,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue
);
  import pscm_pkg::*;

  localparam int NS = 9;
  localparam int NW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int PW = 16 + NW;
  localparam logic [NW-1:0] TOP_IDX = NW'(LOG_TABLE_ENTRIES);

  // Configuration registers.
  field_t      field_select;
  logic        log_scale_enable;
  logic [15:0] brightness;
  logic [31:0] inverse_maximum;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_select     <= FIELD_DENSITY;
      log_scale_enable <= 1'b0;
      brightness       <= 16'd256;
      inverse_maximum  <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FIELD_SELECT: field_select     <= field_t'(cfg_data[2:0]);
        CFG_LOG_SCALE:    log_scale_enable <= cfg_data[0];
        CFG_BRIGHTNESS:   brightness       <= cfg_data[15:0];
        CFG_INV_MAXIMUM:  inverse_maximum  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Log compression table, built at elaboration.
  logic [16:0] log_rom [LOG_TABLE_ENTRIES + 1];
  for (genvar k = 0; k <= LOG_TABLE_ENTRIES; k++) begin : g_rom
    assign log_rom[k] = 17'(log_rom_entry(64'(k), 64'(LOG_TABLE_ENTRIES)));
  end

  // Pipeline control.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) en[s] = !vld[s] || en[s+1];
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // Stage 0: field selection.
  logic signed [31:0] sel_value;
  logic               sel_signed;
  logic signed [31:0] v0;

  always_comb begin
    sel_signed = 1'b0;
    unique case (field_select)
      FIELD_ENERGY: sel_value = energy_value;
      FIELD_SPEED:  sel_value = speed_value;
      FIELD_ACCEL:  sel_value = accel_value;
      FIELD_VEL_X: begin
        sel_value  = vel_x;
        sel_signed = 1'b1;
      end
      FIELD_VEL_Y: begin
        sel_value  = vel_y;
        sel_signed = 1'b1;
      end
      FIELD_VEL_Z: begin
        sel_value  = vel_z;
        sel_signed = 1'b1;
      end
      default:     sel_value = density_value;
    endcase
  end

  // Position and path flags travel with every stage.
  logic signed [31:0] px [NS];
  logic signed [31:0] py [NS];
  logic signed [31:0] pz [NS];
  logic               sgn [NS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px[0]  <= pos_x;
      py[0]  <= pos_y;
      pz[0]  <= pos_z;
      sgn[0] <= sel_signed;
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        px[s]  <= px[s-1];
        py[s]  <= py[s-1];
        pz[s]  <= pz[s-1];
        sgn[s] <= sgn[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) v0 <= sel_value;
  end

  // Stage 1: normalize.
  logic signed [64:0] prod1;
  always_ff @(posedge clk) begin
    if (en[1]) prod1 <= v0 * $signed({1'b0, inverse_maximum});
  end

  // Stage 2: floor shift and saturation to 32 bits.
  logic signed [48:0] sh2;
  logic signed [31:0] nsat2;
  logic signed [31:0] nsat2_c;
  assign sh2 = prod1[64:16];
  always_comb begin
    if (sh2 > 49'sd2147483647)       nsat2_c = 32'sh7FFFFFFF;
    else if (sh2 < -49'sd2147483648) nsat2_c = 32'sh80000000;
    else                             nsat2_c = sh2[31:0];
  end
  always_ff @(posedge clk) begin
    if (en[2]) nsat2 <= nsat2_c;
  end

  // Stage 3: log table lookup.
  logic [16:0]   x3;
  logic [PW-1:0] p3;
  logic [NW-1:0] i3;
  logic [NW-1:0] i3_hi;
  logic signed [31:0] nsat3;
  logic [16:0]   e0_3;
  logic [16:0]   e1_3;
  logic [15:0]   f3;
  logic          uselog3;

  always_comb begin
    if (nsat2 < 0)                     x3 = '0;
    else if (nsat2 > 32'sd65536)       x3 = 17'd65536;
    else                               x3 = nsat2[16:0];
    p3    = PW'(x3 * LOG_TABLE_ENTRIES);
    i3    = p3[16 +: NW];
    i3_hi = (i3 == TOP_IDX) ? TOP_IDX : i3 + NW'(1);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      nsat3   <= nsat2;
      e0_3    <= log_rom[i3];
      e1_3    <= log_rom[i3_hi];
      f3      <= p3[15:0];
      uselog3 <= log_scale_enable && !sgn[2];
    end
  end

  // Stage 4: interpolation.
  logic [32:0]        step4;
  logic signed [31:0] n4;
  assign step4 = 33'(e1_3 - e0_3) * 33'(f3);
  always_ff @(posedge clk) begin
    if (en[4]) n4 <= uselog3 ? $signed({15'd0, e0_3 + step4[32:16]}) : nsat3;
  end

  // Stage 5: brightness.
  logic signed [48:0] bprod5;
  logic signed [40:0] b5;
  assign bprod5 = n4 * $signed({1'b0, brightness});
  always_ff @(posedge clk) begin
    if (en[5]) b5 <= bprod5[48:8];
  end

  // Stage 6: clamp, segment choice and reciprocal estimate of the amount.
  logic [16:0]        tseq6;
  logic signed [17:0] tdiv6_c;
  logic [1:0]         seg6_c;
  logic [15:0]        d6;
  logic [31:0]        num6_c;
  logic [26:0]        rcp6;
  logic [58:0]        qprod6;
  logic signed [17:0] tdiv6;
  logic [1:0]         seg6;
  logic [31:0]        num6;
  logic [16:0]        q6;

  always_comb begin
    if (b5 < 0)                tseq6 = '0;
    else if (b5 > 41'sd65536)  tseq6 = 17'd65536;
    else                       tseq6 = b5[16:0];
    if (b5 < -41'sd65536)      tdiv6_c = -18'sd65536;
    else if (b5 > 41'sd65536)  tdiv6_c = 18'sd65536;
    else                       tdiv6_c = b5[17:0];
    priority if (tseq6 < SEQ_B1) begin
      seg6_c = 2'd0;
      d6     = tseq6[15:0];
      rcp6   = SEG_RCP0;
    end else if (tseq6 < SEQ_B2) begin
      seg6_c = 2'd1;
      d6     = 16'(tseq6 - SEQ_B1);
      rcp6   = SEG_RCP1;
    end else begin
      seg6_c = 2'd2;
      d6     = 16'(tseq6 - SEQ_B2);
      rcp6   = SEG_RCP2;
    end
    num6_c = {d6, 16'd0};
    qprod6 = 59'(num6_c) * 59'(rcp6);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      tdiv6 <= tdiv6_c;
      seg6  <= seg6_c;
      num6  <= num6_c;
      q6    <= qprod6[56:40];
    end
  end

  // Stage 7: amount correction and the diverging ramp.
  logic [14:0] len7;
  logic [31:0] rem7;
  logic [16:0] amount7;
  logic [1:0]  seg7;
  rgb_t        div7_c;
  rgb_t        div7;
  logic [16:0] u7;
  logic [33:0] mr7;
  logic [33:0] mg7;
  logic [33:0] mb7;

  always_comb begin
    unique case (seg6)
      2'd0:    len7 = SEG_LEN0;
      2'd1:    len7 = SEG_LEN1;
      default: len7 = SEG_LEN2;
    endcase
    rem7 = num6 - 32'(q6) * 32'(len7);
    // The estimate is at most one below the true quotient.
    u7 = 17'(tdiv6 + 18'sd65536);
    mr7 = '0;
    mg7 = '0;
    mb7 = '0;
    if (tdiv6 < 0) begin
      mr7 = 34'd47185 * 34'(u7);
      mg7 = 34'd36044 * 34'(u7);
      div7_c.red   = 16'(17'd11796 + mr7[32:16]);
      div7_c.green = 16'(17'd22937 + mg7[32:16]);
      div7_c.blue  = 16'd65535;
    end else begin
      mg7 = 34'd45875 * 34'(tdiv6[16:0]);
      mb7 = 34'd51117 * 34'(tdiv6[16:0]);
      div7_c.red   = 16'd65535;
      div7_c.green = 16'(17'd58982 - mg7[32:16]);
      div7_c.blue  = 16'(17'd58982 - mb7[32:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      amount7 <= (rem7 >= 32'(len7)) ? q6 + 17'd1 : q6;
      seg7    <= seg6;
      div7    <= div7_c;
    end
  end

  // Stage 8: sequential blend and output register.
  rgb_t seq8;
  rgb_t col8;

  pscm_seq_blend u_blend (
    .seg    (seg7),
    .amount (amount7),
    .color  (seq8)
  );

  always_ff @(posedge clk) begin
    if (en[8]) col8 <= sgn[7] ? div7 : seq8;
  end

  assign out_valid = vld[NS-1];
  assign out_x     = px[NS-1];
  assign out_y     = py[NS-1];
  assign out_z     = pz[NS-1];
  assign red       = col8.red;
  assign green     = col8.green;
  assign blue      = col8.blue;

  // The pipeline only pushes back when the output holds a blocked result.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output can drain");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("empty output stage yet input stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-2] && !out_valid) |=> out_valid)
    else $error("finished item did not reach the output stage");

endmodule
